@@ src/flow_peer_accounting_table_macros.svh @@
// assertion macros for the peer accounting table checker
`ifndef FLOW_PEER_ACCOUNTING_TABLE_MACROS_SVH
`define FLOW_PEER_ACCOUNTING_TABLE_MACROS_SVH

// implication checked every clock, skipped while in reset
`define FPA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: %s failed", "label");

// next-cycle implication
`define FPA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: %s failed", "label");

`endif

@@ src/fpa_pkg.sv @@
// ----------------------------------------------------------------------------
// fpa_pkg
// types, sizes and codes shared by the peer accounting table
// ----------------------------------------------------------------------------
package fpa_pkg;

  localparam int MAX_SOURCES = 16;
  localparam int MAX_PEERS   = 16;
  localparam int SW  = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;
  localparam int PW  = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;
  localparam int SCW = $clog2(MAX_SOURCES + 1);
  localparam int PCW = $clog2(MAX_PEERS + 1);
  localparam int AW  = SW + PW;

  localparam logic [2:0] ST_NO_MATCH = 3'd0;
  localparam logic [2:0] ST_UPDATED  = 3'd1;
  localparam logic [2:0] ST_ADDED    = 3'd2;
  localparam logic [2:0] ST_MISSED   = 3'd3;
  localparam logic [2:0] ST_SRC_FULL = 3'd4;
  localparam logic [2:0] ST_HALTED   = 3'd5;

  localparam logic REG_TARGET_AS = 1'b0;
  localparam logic REG_INSP_PORT = 1'b1;

  typedef struct packed {
    logic [31:0] src_as;
    logic [15:0] dst_port;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [31:0] first_time;
    logic [31:0] last_time;
    logic [63:0] pkt_count;
    logic [63:0] byte_count;
    logic [31:0] in_iface;
    logic [31:0] out_iface;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  source_slot;
    logic [3:0]  peer_slot;
    logic [63:0] appearances;
    logic [63:0] total_duration;
    logic [63:0] total_packets;
    logic [63:0] total_octets;
    logic [63:0] total_in;
    logic [63:0] total_out;
    logic [31:0] processed_count;
    logic [31:0] matched_count;
    logic [31:0] missed_count;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SRC_RD, S_SRC_CMP, S_PEER_RD, S_PEER_CMP, S_ACC_RD, S_ACC,
    S_WRITE, S_OUT
  } fsm_t;

  // six 64 bit accumulator lanes, processed one per cycle
  typedef struct packed {
    logic [63:0] appear;
    logic [63:0] dur;
    logic [63:0] pkts;
    logic [63:0] octs;
    logic [63:0] isum;
    logic [63:0] osum;
  } peer_rec_t;

endpackage

@@ src/fpa_peer_mem.sv @@
// ----------------------------------------------------------------------------
// fpa_peer_mem
// peer store: addresses and counters, one write and one registered read port
// ----------------------------------------------------------------------------
module fpa_peer_mem (
  input  logic                   clk,
  input  logic                   we,
  input  logic [fpa_pkg::AW-1:0] waddr,
  input  logic [31:0]            wkey,
  input  fpa_pkg::peer_rec_t     wrec,
  input  logic [fpa_pkg::AW-1:0] raddr,
  output logic [31:0]            rkey,
  output fpa_pkg::peer_rec_t     rrec
);

  localparam int DEPTH = fpa_pkg::MAX_SOURCES * fpa_pkg::MAX_PEERS;

  logic [31:0]        key_mem [DEPTH];
  fpa_pkg::peer_rec_t rec_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      key_mem[waddr] <= wkey;
      rec_mem[waddr] <= wrec;
    end
    rkey <= key_mem[raddr];
    rrec <= rec_mem[raddr];
  end

endmodule

@@ src/fpa_alu.sv @@
// ----------------------------------------------------------------------------
// fpa_alu
// shared 64 bit adder with select: sums one lane per cycle or loads it fresh
// ----------------------------------------------------------------------------
module fpa_alu (
  input  logic [63:0] a,
  input  logic [63:0] b,
  input  logic        load,
  output logic [63:0] y
);

  assign y = load ? b : (a + b);

endmodule

@@ src/flow_peer_accounting_table.sv @@
// a record that does not match, or any record when halted, goes straight to the
// result beat; a matching record scans the source table, then the peer table
// throughput: one record at a time, in_ready low until the result beat is taken;
// set by the one-entry-per-cycle source scan, the peer scan through the single
// read port of the peer store and one shared 64 bit adder
// reset: counters, fill counts, halt flag, scan indices and config registers cleared; stores, payload and result not
// ----------------------------------------------------------------------------
// flow_peer_accounting_table
// per-source peer accounting of flow records matching an AS and a port
// ----------------------------------------------------------------------------
module flow_peer_accounting_table (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  fpa_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output fpa_pkg::out_item_t out_data,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [2:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);

  localparam int SW = fpa_pkg::SW;
  localparam int PW = fpa_pkg::PW;

  fpa_pkg::fsm_t state_r, state_nxt;

  logic [15:0] target_as_r, insp_port_r;
  fpa_pkg::in_item_t item_r;

  logic [31:0] src_addrs_r [fpa_pkg::MAX_SOURCES];
  logic [fpa_pkg::SCW-1:0] src_used_r;
  logic [fpa_pkg::PCW-1:0] peer_used_r [fpa_pkg::MAX_SOURCES];
  logic [31:0] processed_r, matched_r, missed_r;
  logic halted_r;

  logic [fpa_pkg::SCW-1:0] sidx_r;
  logic [fpa_pkg::PCW-1:0] pidx_r;
  logic [2:0] lane_r;
  logic       is_new_r;
  fpa_pkg::peer_rec_t acc_r;
  fpa_pkg::out_item_t out_r;

  // memory
  logic [fpa_pkg::AW-1:0] raddr, waddr;
  logic [31:0] rkey;
  fpa_pkg::peer_rec_t rrec;
  logic mem_we;

  assign raddr = {sidx_r[SW-1:0], pidx_r[PW-1:0]};
  assign waddr = raddr;
  assign mem_we = (state_r == fpa_pkg::S_WRITE);

  fpa_peer_mem u_mem (
    .clk, .we(mem_we), .waddr, .wkey(item_r.dst_addr), .wrec(acc_r),
    .raddr, .rkey, .rrec
  );

  // alu lane select
  logic [63:0] alu_a, alu_b, alu_y;
  always_comb begin
    alu_a = 64'd0;
    alu_b = 64'd0;
    case (lane_r)
      3'd0: begin alu_a = acc_r.appear; alu_b = 64'd1; end
      3'd1: begin
        alu_a = acc_r.dur;
        alu_b = {32'd0, item_r.last_time - item_r.first_time};
      end
      3'd2: begin alu_a = acc_r.pkts; alu_b = item_r.pkt_count; end
      3'd3: begin alu_a = acc_r.octs; alu_b = item_r.byte_count; end
      3'd4: begin alu_a = acc_r.isum; alu_b = {32'd0, item_r.in_iface}; end
      3'd5: begin alu_a = acc_r.osum; alu_b = {32'd0, item_r.out_iface}; end
      default: ;
    endcase
  end

  fpa_alu u_alu (.a(alu_a), .b(alu_b), .load(is_new_r), .y(alu_y));

  logic match_rec, src_at_end, peer_at_end;
  logic [fpa_pkg::PCW-1:0] cur_pused;
  assign match_rec = (item_r.src_as == {16'd0, target_as_r}) &&
                     (item_r.dst_port == insp_port_r);
  assign cur_pused = peer_used_r[sidx_r[SW-1:0]];
  assign src_at_end = (sidx_r == src_used_r);
  assign peer_at_end = (pidx_r == cur_pused);

  assign in_ready = (state_r == fpa_pkg::S_IDLE);
  assign out_valid = (state_r == fpa_pkg::S_OUT);
  assign out_data = out_r;
  assign cfg_pready = 1'b1;

  always_comb begin
    cfg_prdata = 32'd0;
    case (cfg_paddr[2])
      fpa_pkg::REG_TARGET_AS: cfg_prdata = {16'd0, target_as_r};
      fpa_pkg::REG_INSP_PORT: cfg_prdata = {16'd0, insp_port_r};
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      fpa_pkg::S_IDLE:   if (in_valid) state_nxt = fpa_pkg::S_SRC_CMP;
      fpa_pkg::S_SRC_CMP: begin
        if (halted_r || !match_rec) state_nxt = fpa_pkg::S_OUT;
        else if (src_at_end) begin
          if (src_used_r == fpa_pkg::SCW'(fpa_pkg::MAX_SOURCES))
            state_nxt = fpa_pkg::S_OUT;
          else state_nxt = fpa_pkg::S_PEER_RD;
        end else if (src_addrs_r[sidx_r[SW-1:0]] == item_r.src_addr)
          state_nxt = fpa_pkg::S_PEER_RD;
      end
      fpa_pkg::S_PEER_RD: begin
        if (peer_at_end) begin
          if (cur_pused == fpa_pkg::PCW'(fpa_pkg::MAX_PEERS))
            state_nxt = fpa_pkg::S_OUT;
          else state_nxt = fpa_pkg::S_ACC;
        end else state_nxt = fpa_pkg::S_PEER_CMP;
      end
      fpa_pkg::S_PEER_CMP:
        state_nxt = (rkey == item_r.dst_addr) ? fpa_pkg::S_ACC_RD : fpa_pkg::S_PEER_RD;
      fpa_pkg::S_ACC_RD: state_nxt = fpa_pkg::S_ACC;
      fpa_pkg::S_ACC:    if (lane_r == 3'd5) state_nxt = fpa_pkg::S_WRITE;
      fpa_pkg::S_WRITE:  state_nxt = fpa_pkg::S_OUT;
      fpa_pkg::S_OUT:    if (out_ready) state_nxt = fpa_pkg::S_IDLE;
      default:           state_nxt = fpa_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= fpa_pkg::S_IDLE;
    else        state_r <= state_nxt;
  end

  // config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_as_r <= 16'd0;
      insp_port_r <= 16'd0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[1:0] == 2'd0) begin
      case (cfg_paddr[2])
        fpa_pkg::REG_TARGET_AS: target_as_r <= cfg_pwdata[15:0];
        fpa_pkg::REG_INSP_PORT: insp_port_r <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_used_r  <= '0;
      processed_r <= '0;
      matched_r   <= '0;
      missed_r    <= '0;
      halted_r    <= 1'b0;
      sidx_r      <= '0;
      pidx_r      <= '0;
      lane_r      <= '0;
      is_new_r    <= 1'b0;
      for (int i = 0; i < fpa_pkg::MAX_SOURCES; i++) peer_used_r[i] <= '0;
    end else begin
      case (state_r)
        fpa_pkg::S_IDLE: begin
          sidx_r <= '0;
          pidx_r <= '0;
          lane_r <= '0;
          is_new_r <= 1'b0;
        end
        fpa_pkg::S_SRC_CMP: begin
          if (!halted_r && match_rec) begin
            if (src_at_end) begin
              if (src_used_r == fpa_pkg::SCW'(fpa_pkg::MAX_SOURCES)) halted_r <= 1'b1;
              else begin
                src_used_r <= src_used_r + 1'b1;
                peer_used_r[sidx_r[SW-1:0]] <= '0;
              end
            end else if (src_addrs_r[sidx_r[SW-1:0]] != item_r.src_addr)
              sidx_r <= sidx_r + 1'b1;
          end else if (!halted_r) processed_r <= processed_r + 1'b1;
        end
        fpa_pkg::S_PEER_RD: begin
          if (peer_at_end) begin
            if (cur_pused == fpa_pkg::PCW'(fpa_pkg::MAX_PEERS)) begin
              missed_r <= missed_r + 1'b1;
              matched_r <= matched_r + 1'b1;
              processed_r <= processed_r + 1'b1;
            end else begin
              is_new_r <= 1'b1;
              peer_used_r[sidx_r[SW-1:0]] <= cur_pused + 1'b1;
            end
          end
        end
        fpa_pkg::S_PEER_CMP:
          if (rkey != item_r.dst_addr) pidx_r <= pidx_r + 1'b1;
        fpa_pkg::S_ACC: lane_r <= lane_r + 1'b1;
        fpa_pkg::S_WRITE: begin
          matched_r <= matched_r + 1'b1;
          processed_r <= processed_r + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (state_r == fpa_pkg::S_IDLE && in_valid) item_r <= in_data;
    if (state_r == fpa_pkg::S_SRC_CMP && !halted_r && match_rec && src_at_end &&
        src_used_r != fpa_pkg::SCW'(fpa_pkg::MAX_SOURCES))
      src_addrs_r[sidx_r[SW-1:0]] <= item_r.src_addr;
    if (state_r == fpa_pkg::S_ACC_RD) acc_r <= rrec;
    if (state_r == fpa_pkg::S_ACC) begin
      case (lane_r)
        3'd0: acc_r.appear <= alu_y;
        3'd1: acc_r.dur    <= alu_y;
        3'd2: acc_r.pkts   <= alu_y;
        3'd3: acc_r.octs   <= alu_y;
        3'd4: acc_r.isum   <= alu_y;
        3'd5: acc_r.osum   <= alu_y;
        default: ;
      endcase
    end
  end

  // result beat assembly
  logic [2:0] res_status;
  logic       res_peer, res_src;
  always_comb begin
    res_status = fpa_pkg::ST_NO_MATCH;
    res_peer = 1'b0;
    res_src = 1'b0;
    case (state_r)
      fpa_pkg::S_SRC_CMP: begin
        if (halted_r) res_status = fpa_pkg::ST_HALTED;
        else if (!match_rec) res_status = fpa_pkg::ST_NO_MATCH;
        else res_status = fpa_pkg::ST_SRC_FULL;
      end
      fpa_pkg::S_PEER_RD: begin res_status = fpa_pkg::ST_MISSED; res_src = 1'b1; end
      fpa_pkg::S_WRITE: begin
        res_status = is_new_r ? fpa_pkg::ST_ADDED : fpa_pkg::ST_UPDATED;
        res_src = 1'b1;
        res_peer = 1'b1;
      end
      default: ;
    endcase
  end

  logic load_out;
  assign load_out = (state_nxt == fpa_pkg::S_OUT) && (state_r != fpa_pkg::S_OUT);

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_r.status      <= res_status;
      out_r.source_slot <= res_src ? 4'(sidx_r) : 4'd0;
      out_r.peer_slot   <= res_peer ? 4'(pidx_r) : 4'd0;
      out_r.appearances    <= res_peer ? acc_r.appear : 64'd0;
      out_r.total_duration <= res_peer ? acc_r.dur : 64'd0;
      out_r.total_packets  <= res_peer ? acc_r.pkts : 64'd0;
      out_r.total_octets   <= res_peer ? acc_r.octs : 64'd0;
      out_r.total_in       <= res_peer ? acc_r.isum : 64'd0;
      out_r.total_out      <= res_peer ? acc_r.osum : 64'd0;
      // counters as they will stand after this record
      out_r.processed_count <= processed_r +
        32'((res_status != fpa_pkg::ST_HALTED && res_status != fpa_pkg::ST_SRC_FULL) ? 1 : 0);
      out_r.matched_count <= matched_r +
        32'((res_status == fpa_pkg::ST_UPDATED || res_status == fpa_pkg::ST_ADDED ||
             res_status == fpa_pkg::ST_MISSED) ? 1 : 0);
      out_r.missed_count <= missed_r + 32'((res_status == fpa_pkg::ST_MISSED) ? 1 : 0);
    end
  end

endmodule

@@ src/fpa_checker.sv @@
// ----------------------------------------------------------------------------
// fpa_checker
// port-level checks of the peer accounting table
// ----------------------------------------------------------------------------
`include "flow_peer_accounting_table_macros.svh"

module fpa_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input fpa_pkg::out_item_t out_data
);

  // one record at a time: no new beat while a result is pending
  `FPA_ASSERT_IMP(a_excl, clk, rst_n, out_valid, !in_ready)
  // a taken input beat is followed by a busy block
  `FPA_ASSERT_NXT(a_busy, clk, rst_n, in_valid && in_ready, !in_ready)
  // result held while stalled
  `FPA_ASSERT_NXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))
  // status stays within the defined code range
  `FPA_ASSERT_IMP(a_stat, clk, rst_n, out_valid, out_data.status <= fpa_pkg::ST_HALTED)

endmodule

bind flow_peer_accounting_table fpa_checker u_fpa_checker (
  .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .out_data
);

@@ sim/flow_peer_accounting_table_test.sv @@
// ----------------------------------------------------------------------------
// flow_peer_accounting_table_test
// drives flow records through the peer accounting table under random idling
// and backpressure, predicts each result beat from an own copy of the source
// and peer tables, and compares every field
// ----------------------------------------------------------------------------
module flow_peer_accounting_table_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int NUM_SRC_POOL   = 12;
  localparam int NUM_DST_POOL   = 24;
  localparam logic [2:0] ADDR_TARGET_AS = {fpa_pkg::REG_TARGET_AS, 2'b00};
  localparam logic [2:0] ADDR_INSP_PORT = {fpa_pkg::REG_INSP_PORT, 2'b00};

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  fpa_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  fpa_pkg::out_item_t out_data;
  logic               cfg_psel = 1'b0;
  logic               cfg_penable = 1'b0;
  logic               cfg_pwrite = 1'b0;
  logic [2:0]         cfg_paddr = '0;
  logic [31:0]        cfg_pwdata = '0;
  logic [31:0]        cfg_prdata;
  logic               cfg_pready;

  flow_peer_accounting_table dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // own copy of the tables and registers
  logic [15:0]        match_as, match_port;
  logic [31:0]        src_key[fpa_pkg::MAX_SOURCES];
  int                 src_fill;
  int                 peer_fill[fpa_pkg::MAX_SOURCES];
  logic [31:0]        peer_key[fpa_pkg::MAX_SOURCES][fpa_pkg::MAX_PEERS];
  fpa_pkg::peer_rec_t peer_acc[fpa_pkg::MAX_SOURCES][fpa_pkg::MAX_PEERS];
  logic [31:0]        n_processed, n_matched, n_missed;
  logic               halt_seen;

  fpa_pkg::out_item_t expected_totals[$];
  int                 errors = 0;
  int                 stall_req = 0;
  logic [31:0]        src_pool[NUM_SRC_POOL];
  logic [31:0]        dst_pool[NUM_DST_POOL];

  function automatic fpa_pkg::out_item_t account_record(input fpa_pkg::in_item_t r);
    fpa_pkg::out_item_t o;
    int s, p;
    logic [63:0] dur;
    o = '0;
    dur = {32'd0, r.last_time - r.first_time};
    if (halt_seen) begin
      o.status = fpa_pkg::ST_HALTED;
    end else if (r.src_as != {16'd0, match_as} || r.dst_port != match_port) begin
      n_processed++;
      o.status = fpa_pkg::ST_NO_MATCH;
    end else begin
      s = 0;
      while (s < src_fill && src_key[s] != r.src_addr) s++;
      if (s == src_fill && src_fill == fpa_pkg::MAX_SOURCES) begin
        halt_seen = 1'b1;
        o.status = fpa_pkg::ST_SRC_FULL;
      end else begin
        if (s == src_fill) begin
          src_key[s] = r.src_addr;
          peer_fill[s] = 0;
          src_fill++;
        end
        p = 0;
        while (p < peer_fill[s] && peer_key[s][p] != r.dst_addr) p++;
        n_matched++;
        n_processed++;
        o.source_slot = s[3:0];
        if (p < peer_fill[s] || peer_fill[s] < fpa_pkg::MAX_PEERS) begin
          if (p < peer_fill[s]) begin
            peer_acc[s][p].appear += 64'd1;
            peer_acc[s][p].dur    += dur;
            peer_acc[s][p].pkts   += r.pkt_count;
            peer_acc[s][p].octs   += r.byte_count;
            peer_acc[s][p].isum   += {32'd0, r.in_iface};
            peer_acc[s][p].osum   += {32'd0, r.out_iface};
            o.status = fpa_pkg::ST_UPDATED;
          end else begin
            peer_key[s][p] = r.dst_addr;
            peer_acc[s][p] = '{64'd1, dur, r.pkt_count, r.byte_count,
                               {32'd0, r.in_iface}, {32'd0, r.out_iface}};
            peer_fill[s]++;
            o.status = fpa_pkg::ST_ADDED;
          end
          o.peer_slot      = p[3:0];
          o.appearances    = peer_acc[s][p].appear;
          o.total_duration = peer_acc[s][p].dur;
          o.total_packets  = peer_acc[s][p].pkts;
          o.total_octets   = peer_acc[s][p].octs;
          o.total_in       = peer_acc[s][p].isum;
          o.total_out      = peer_acc[s][p].osum;
        end else begin
          n_missed++;
          o.status = fpa_pkg::ST_MISSED;
        end
      end
    end
    o.processed_count = n_processed;
    o.matched_count   = n_matched;
    o.missed_count    = n_missed;
    return o;
  endfunction

  // mostly short gaps, a few long ones, and runs of none
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_record(input fpa_pkg::in_item_t r);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (!in_ready);
    expected_totals.push_back(account_record(r));
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [15:0] value);
    in_valid <= 1'b0;
    wait (expected_totals.size() == 0);
    repeat (20) @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= {$urandom_range(0, 65535), value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    if (addr == ADDR_TARGET_AS) match_as = value;
    else match_port = value;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  function automatic fpa_pkg::in_item_t make_record(input bit hit, input logic [31:0] sa,
                                                    input logic [31:0] da);
    fpa_pkg::in_item_t r;
    r.src_as     = hit ? {16'd0, match_as} : $urandom;
    r.dst_port   = hit ? match_port : $urandom_range(0, 65535);
    r.src_addr   = sa;
    r.dst_addr   = da;
    r.first_time = $urandom;
    r.last_time  = $urandom;
    r.pkt_count  = {$urandom, $urandom};
    r.byte_count = {$urandom, $urandom};
    r.in_iface   = $urandom;
    r.out_iface  = $urandom;
    return r;
  endfunction

  task automatic test_directed_defaults();
    fpa_pkg::in_item_t r;
    r = make_record(1, src_pool[0], dst_pool[0]);
    r.pkt_count = '1; r.byte_count = '1; r.in_iface = '1; r.out_iface = '1;
    r.first_time = 32'd0; r.last_time = '1;
    send_record(r);
    // same peer again so the packet and octet accumulators wrap
    r.first_time = '1; r.last_time = 32'd0;
    send_record(r);
    send_record(r);
    r = make_record(1, src_pool[0], dst_pool[1]);
    r.pkt_count = '0; r.byte_count = '0; r.in_iface = '0; r.out_iface = '0;
    r.first_time = 32'd5; r.last_time = 32'd5;
    send_record(r);
    r = make_record(1, src_pool[11], 32'd0);
    send_record(r);
    r = make_record(1, src_pool[11], '1);
    send_record(r);
    // low half matches, upper half of the AS does not
    r = make_record(1, src_pool[2], dst_pool[2]);
    r.src_as[31:16] = 16'hffff;
    send_record(r);
    r = make_record(1, src_pool[2], dst_pool[2]);
    r.dst_port = 16'd1;
    send_record(r);
  endtask

  task automatic test_config_extremes();
    fpa_pkg::in_item_t r;
    write_reg(ADDR_TARGET_AS, 16'hffff);
    write_reg(ADDR_INSP_PORT, 16'hffff);
    for (int i = 0; i < 4; i++) begin
      r = make_record(i != 3, src_pool[i], dst_pool[i]);
      send_record(r);
    end
    r = make_record(1, src_pool[0], dst_pool[0]);
    r.src_as = 32'h0000_fffe;
    send_record(r);
  endtask

  task automatic test_peer_table_full();
    for (int k = 0; k <= fpa_pkg::MAX_PEERS + 1; k++)
      send_record(make_record(1, src_pool[1], 32'h5000_0000 + k));
    send_record(make_record(1, src_pool[1], 32'h5000_0003));
  endtask

  task automatic test_random_traffic(input int count);
    int si, di;
    logic [31:0] da;
    for (int i = 0; i < count; i++) begin
      si = $urandom_range(0, NUM_SRC_POOL - 1);
      di = $urandom_range(0, NUM_DST_POOL - 1);
      da = ($urandom_range(0, 9) == 0) ? $urandom : dst_pool[di];
      send_record(make_record($urandom_range(0, 9) < 7, src_pool[si], da));
    end
  endtask

  task automatic test_backpressure();
    stall_req = 300;
    test_random_traffic(30);
  endtask

  task automatic test_source_full_halt();
    for (int k = 0; k < fpa_pkg::MAX_SOURCES + 2 && !halt_seen; k++)
      send_record(make_record(1, 32'hc000_0000 + k, dst_pool[0]));
    test_random_traffic(6);
  endtask

  // receiver: random stalls, plus a long hold-off on request
  int stall_left = 0;
  always @(posedge clk) begin
    if (stall_req > 0) begin
      stall_left = stall_req;
      stall_req = 0;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      stall_left = pick_gap();
      out_ready <= (stall_left == 0);
    end
  end

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t mismatch %s: expected %h actual %h", $realtime, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    fpa_pkg::out_item_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_totals.size() == 0) begin
        errors++;
        $display("%0t unexpected result beat: expected none actual %h", $realtime,
                 out_data);
      end else begin
        e = expected_totals.pop_front();
        check_field("status", e.status, out_data.status);
        check_field("source_slot", e.source_slot, out_data.source_slot);
        check_field("peer_slot", e.peer_slot, out_data.peer_slot);
        check_field("appearances", e.appearances, out_data.appearances);
        check_field("total_duration", e.total_duration, out_data.total_duration);
        check_field("total_packets", e.total_packets, out_data.total_packets);
        check_field("total_octets", e.total_octets, out_data.total_octets);
        check_field("total_in", e.total_in, out_data.total_in);
        check_field("total_out", e.total_out, out_data.total_out);
        check_field("processed_count", e.processed_count, out_data.processed_count);
        check_field("matched_count", e.matched_count, out_data.matched_count);
        check_field("missed_count", e.missed_count, out_data.missed_count);
      end
    end
  end

  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_psel) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL flow_peer_accounting_table");
      $finish;
    end
  end

  initial begin
    match_as = '0;
    match_port = '0;
    src_fill = 0;
    for (int s = 0; s < fpa_pkg::MAX_SOURCES; s++) peer_fill[s] = 0;
    n_processed = '0;
    n_matched = '0;
    n_missed = '0;
    halt_seen = 1'b0;
    for (int i = 0; i < NUM_SRC_POOL; i++) src_pool[i] = {i[3:0], 28'($urandom)};
    src_pool[0] = 32'd0;
    src_pool[NUM_SRC_POOL - 1] = '1;
    for (int i = 0; i < NUM_DST_POOL; i++) dst_pool[i] = $urandom;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_defaults();
    test_config_extremes();
    test_peer_table_full();
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(ADDR_TARGET_AS, (ph == 0) ? 16'd0 : 16'($urandom));
      write_reg(ADDR_INSP_PORT, (ph == 0) ? 16'd0 : 16'($urandom));
      test_random_traffic(400);
    end
    test_backpressure();
    test_source_full_halt();

    in_valid <= 1'b0;
    wait (expected_totals.size() == 0);
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("PASS flow_peer_accounting_table");
    end else begin
      $display("FAIL flow_peer_accounting_table");
    end
    $finish;
  end
endmodule
